@@ src/lzhd_pkg.sv @@
// package for the lz huffman length decompressor
// holds payload types, tree node type, sizes and result codes; no dependencies
package lzhd_pkg;

    // sizes
    localparam int WINDOW         = 4096;
    localparam int MAX_NODES      = 64;
    localparam int MAX_VALUE_BITS = 24;
    localparam int HIST_AW        = $clog2(WINDOW);
    localparam int NODE_AW        = $clog2(MAX_NODES);
    localparam int TREE_AW        = NODE_AW + 1;

    // status codes
    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_MORE  = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_MAGIC    = 3'd1;
    localparam logic [2:0] ERR_METHOD   = 3'd2;
    localparam logic [2:0] ERR_DISTANCE = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW = 3'd4;
    localparam logic [2:0] ERR_WIDE     = 3'd5;

    // request kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_PULL = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] stream_byte;
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic [2:0] error_code;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic               is_leaf;
        logic [7:0]         bits;
        logic [NODE_AW-1:0] lo;
        logic [NODE_AW-1:0] hi;
    } node_t;

    // header magic bytes
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h76;
            2'd1:    b = 8'h70;
            2'd2:    b = 8'h6b;
            default: b = 8'h30;
        endcase
        return b;
    endfunction

endpackage

@@ src/lzhd_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module lzhd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/lz_huffman_length_decompressor.sv @@
// top level of the lz huffman length decompressor
// depends on lzhd_pkg and lzhd_ram
//
// Usage: requests arrive on cmd (cmd_valid / cmd_stall). kind 0 pushes one
// compressed byte, kind 1 pulls the next output byte. A push gives no result;
// a pull gives exactly one result on res (res_valid / res_stall) carrying the
// byte, a status, an error code and a last flag.
// Flow: a request is handled alone. A header push only updates the header
// state; any other push appends the byte to the bit buffer if it has room,
// then builds as much of the trees as the buffered bits allow, one node at a
// time; leaf counts are shifted out one bit per cycle. A pull walks the code
// trees one node per code bit and shifts out the raw value bits, or copies
// the next byte of a running copy out of the history ram. The serial bit
// extractor and the single read port of each ram set the pace.
// cmd_stall is high while a request is being worked on.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls and a second result is ready, the block
// holds it and keeps cmd_stall high until the register frees.
// Reset puts the block in the header phase with empty buffers; the rams are
// not cleared and are only read where written.
module lz_huffman_length_decompressor
    import lzhd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output rsp_t res
);

    // decode phases
    localparam logic [3:0] PH_HEADER = 4'd0;
    localparam logic [3:0] PH_DTREE  = 4'd1;
    localparam logic [3:0] PH_LTREE  = 4'd2;
    localparam logic [3:0] PH_FLAG   = 4'd3;
    localparam logic [3:0] PH_LIT    = 4'd4;
    localparam logic [3:0] PH_DIST1  = 4'd5;
    localparam logic [3:0] PH_DIST2  = 4'd6;
    localparam logic [3:0] PH_LEN    = 4'd7;
    localparam logic [3:0] PH_ERROR  = 4'd8;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BUILD = 4'd1;
    localparam logic [3:0] S_JOIN  = 4'd2;
    localparam logic [3:0] S_BITS  = 4'd3;
    localparam logic [3:0] S_VALUE = 4'd4;
    localparam logic [3:0] S_PULL  = 4'd5;
    localparam logic [3:0] S_STEP  = 4'd6;
    localparam logic [3:0] S_WALK  = 4'd7;
    localparam logic [3:0] S_DCHK  = 4'd8;
    localparam logic [3:0] S_CPRD  = 4'd9;
    localparam logic [3:0] S_CPWR  = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;

    logic [3:0]         state_reg, state_next;
    logic [3:0]         phase_reg, phase_next;
    logic [31:0]        buf_reg, buf_next;
    logic [5:0]         held_reg, held_next;
    logic [31:0]        total_reg, total_next;
    logic               method_reg, method_next;
    logic [3:0]         hdr_cnt_reg, hdr_cnt_next;
    logic [2:0]         err_reg, err_next;
    logic [NODE_AW:0]   depth_reg, depth_next;
    logic [NODE_AW:0]   nc_reg, nc_next;
    logic [NODE_AW-1:0] top_reg, top_next;
    logic [NODE_AW-1:0] walk_reg, walk_next;
    logic [NODE_AW-1:0] droot_reg, droot_next;
    logic [NODE_AW-1:0] lroot_reg, lroot_next;
    logic               dempty_reg, dempty_next;
    logic               lempty_reg, lempty_next;
    logic [31:0]        produced_reg, produced_next;
    logic [12:0]        cdist_reg, cdist_next;
    logic [23:0]        crem_reg, crem_next;
    logic [23:0]        first_reg, first_next;
    logic [23:0]        acc_reg, acc_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic signed [27:0] dist_reg, dist_next;
    rsp_t               pend_reg, pend_next;
    logic               res_valid_reg, res_valid_next;
    rsp_t               res_reg, res_next;

    // ram ports
    logic               tree_we, tree_re;
    logic [TREE_AW-1:0] tree_waddr, tree_raddr;
    node_t              tree_wnode, tree_rnode;
    logic [20:0]        tree_rdata;
    logic               stack_we, stack_re;
    logic [NODE_AW-1:0] stack_waddr, stack_raddr, stack_rdata, stack_wdata;
    logic               hist_we, hist_re;
    logic [HIST_AW-1:0] hist_waddr, hist_raddr;
    logic [7:0]         hist_wdata, hist_rdata;

    logic [5:0]         held_m1;
    logic               cur_bit;
    logic               out_free;
    logic [31:0]        produced_p1;
    logic [31:0]        copy_src;
    logic               dist_bad;
    rsp_t               more_rsp;

    // stack address helpers
    function automatic logic [NODE_AW-1:0] depth_m1(input logic [NODE_AW:0] d);
        logic [NODE_AW:0] t;
        t = d - 1'b1;
        return t[NODE_AW-1:0];
    endfunction

    function automatic logic [NODE_AW-1:0] depth_m2(input logic [NODE_AW:0] d);
        logic [NODE_AW:0] t;
        t = d - 2'd2;
        return t[NODE_AW-1:0];
    endfunction

    assign held_m1     = held_reg - 6'd1;
    assign cur_bit     = buf_reg[held_m1[4:0]];
    assign out_free    = !res_valid_reg || !res_stall;
    assign produced_p1 = produced_reg + 32'd1;
    assign copy_src    = produced_reg - {19'd0, cdist_reg};
    assign tree_rnode  = node_t'(tree_rdata);
    assign more_rsp    = '{out_byte: 8'd0, status: ST_MORE, error_code: ERR_NONE, last: 1'b0};

    // distance range check
    assign dist_bad = (dist_reg <= 28'sd0)
        || ($signed({{6{dist_reg[27]}}, dist_reg}) > $signed({2'b00, produced_reg}))
        || (dist_reg > 28'(WINDOW));

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    lzhd_ram #(.WIDTH(21), .DEPTH(2 * MAX_NODES)) u_tree_ram (
        .clk     (clk),
        .wr_en   (tree_we),
        .wr_addr (tree_waddr),
        .wr_data (tree_wnode),
        .rd_en   (tree_re),
        .rd_addr (tree_raddr),
        .rd_data (tree_rdata)
    );

    lzhd_ram #(.WIDTH(NODE_AW), .DEPTH(MAX_NODES)) u_stack_ram (
        .clk     (clk),
        .wr_en   (stack_we),
        .wr_addr (stack_waddr),
        .wr_data (stack_wdata),
        .rd_en   (stack_re),
        .rd_addr (stack_raddr),
        .rd_data (stack_rdata)
    );

    lzhd_ram #(.WIDTH(8), .DEPTH(WINDOW)) u_hist_ram (
        .clk     (clk),
        .wr_en   (hist_we),
        .wr_addr (hist_waddr),
        .wr_data (hist_wdata),
        .rd_en   (hist_re),
        .rd_addr (hist_raddr),
        .rd_data (hist_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        buf_next      = buf_reg;
        held_next     = held_reg;
        total_next    = total_reg;
        method_next   = method_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        err_next      = err_reg;
        depth_next    = depth_reg;
        nc_next       = nc_reg;
        top_next      = top_reg;
        walk_next     = walk_reg;
        droot_next    = droot_reg;
        lroot_next    = lroot_reg;
        dempty_next   = dempty_reg;
        lempty_next   = lempty_reg;
        produced_next = produced_reg;
        cdist_next    = cdist_reg;
        crem_next     = crem_reg;
        first_next    = first_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        dist_next     = dist_reg;
        pend_next     = pend_reg;

        tree_we     = 1'b0;
        tree_waddr  = {(phase_reg == PH_LTREE), nc_reg[NODE_AW-1:0]};
        tree_wnode  = '{is_leaf: 1'b1, bits: acc_reg[7:0], lo: '0, hi: '0};
        tree_re     = 1'b0;
        tree_raddr  = {(phase_reg == PH_LEN), walk_reg};
        stack_we    = 1'b0;
        stack_waddr = depth_m1(depth_reg);
        stack_wdata = top_reg;
        stack_re    = 1'b0;
        stack_raddr = depth_m2(depth_reg);
        hist_we     = 1'b0;
        hist_waddr  = produced_reg[HIST_AW-1:0];
        hist_wdata  = acc_reg[7:0];
        hist_re     = 1'b0;
        hist_raddr  = copy_src[HIST_AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == KIND_PULL)
                    begin
                        state_next = S_PULL;
                    end
                    else if (phase_reg == PH_HEADER)
                    begin
                        // header bytes: magic, size, method
                        hdr_cnt_next = hdr_cnt_reg + 4'd1;
                        if (hdr_cnt_reg < 4'd4)
                        begin
                            if (cmd.stream_byte != magic_byte(hdr_cnt_reg[1:0]))
                            begin
                                err_next   = ERR_MAGIC;
                                phase_next = PH_ERROR;
                            end
                        end
                        else if (hdr_cnt_reg < 4'd8)
                        begin
                            total_next = {total_reg[23:0], cmd.stream_byte};
                        end
                        else if (cmd.stream_byte > 8'd1)
                        begin
                            err_next   = ERR_METHOD;
                            phase_next = PH_ERROR;
                        end
                        else
                        begin
                            method_next = cmd.stream_byte[0];
                            phase_next  = PH_DTREE;
                            depth_next  = '0;
                            nc_next     = '0;
                        end
                    end
                    else if (phase_reg != PH_ERROR)
                    begin
                        // append to the bit buffer if it has room, then build what we can
                        if (held_reg <= 6'd24)
                        begin
                            buf_next  = {buf_reg[23:0], cmd.stream_byte};
                            held_next = held_reg + 6'd8;
                        end
                        state_next = S_BUILD;
                    end
                end
            end

            S_BUILD:
            begin
                if ((phase_reg != PH_DTREE && phase_reg != PH_LTREE) || held_reg == 6'd0)
                begin
                    state_next = S_IDLE;
                end
                else if (cur_bit)
                begin
                    held_next = held_m1;
                    if (depth_reg <= 7'd1)
                    begin
                        // end of tree
                        if (phase_reg == PH_DTREE)
                        begin
                            dempty_next = (depth_reg == 7'd0);
                            droot_next  = (depth_reg == 7'd0) ? '0 : top_reg;
                            phase_next  = PH_LTREE;
                            depth_next  = '0;
                            nc_next     = '0;
                        end
                        else
                        begin
                            lempty_next = (depth_reg == 7'd0);
                            lroot_next  = (depth_reg == 7'd0) ? '0 : top_reg;
                            phase_next  = PH_FLAG;
                            state_next  = S_IDLE;
                        end
                    end
                    else if (nc_reg >= 7'(MAX_NODES))
                    begin
                        err_next   = ERR_OVERFLOW;
                        phase_next = PH_ERROR;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        stack_re   = 1'b1;
                        state_next = S_JOIN;
                    end
                end
                else if (held_reg < 6'd9)
                begin
                    state_next = S_IDLE;
                end
                else if (nc_reg >= 7'(MAX_NODES) || depth_reg >= 7'(MAX_NODES))
                begin
                    err_next   = ERR_OVERFLOW;
                    phase_next = PH_ERROR;
                    state_next = S_IDLE;
                end
                else
                begin
                    // leaf: drop the flag bit and shift out the count
                    held_next  = held_m1;
                    cnt_next   = 5'd8;
                    acc_next   = '0;
                    state_next = S_BITS;
                end
            end

            S_JOIN:
            begin
                // lower entry from the stack ram, upper entry is the top
                tree_we    = 1'b1;
                tree_wnode = '{is_leaf: 1'b0, bits: 8'd0, lo: stack_rdata, hi: top_reg};
                top_next   = nc_reg[NODE_AW-1:0];
                depth_next = depth_reg - 7'd1;
                nc_next    = nc_reg + 7'd1;
                state_next = S_BUILD;
            end

            S_BITS:
            begin
                // one raw bit per cycle
                if (cnt_reg == 5'd0)
                begin
                    state_next = S_VALUE;
                end
                else
                begin
                    acc_next  = {acc_reg[22:0], cur_bit};
                    held_next = held_m1;
                    cnt_next  = cnt_reg - 5'd1;
                end
            end

            S_VALUE:
            begin
                case (phase_reg)
                    PH_DTREE, PH_LTREE:
                    begin
                        tree_we = 1'b1;
                        if (depth_reg != 7'd0)
                        begin
                            stack_we = 1'b1;
                        end
                        top_next   = nc_reg[NODE_AW-1:0];
                        depth_next = depth_reg + 7'd1;
                        nc_next    = nc_reg + 7'd1;
                        state_next = S_BUILD;
                    end
                    PH_LIT:
                    begin
                        hist_we       = 1'b1;
                        produced_next = produced_p1;
                        phase_next    = PH_FLAG;
                        pend_next     = '{out_byte: acc_reg[7:0], status: ST_BYTE,
                                          error_code: ERR_NONE,
                                          last: (produced_p1 == total_reg)};
                        state_next    = S_EMIT;
                    end
                    PH_DIST1:
                    begin
                        if (method_reg && acc_reg < 24'd3)
                        begin
                            first_next = acc_reg;
                            walk_next  = droot_reg;
                            phase_next = PH_DIST2;
                            state_next = S_STEP;
                        end
                        else
                        begin
                            dist_next = method_reg
                                ? $signed({2'b00, acc_reg, 2'b00}) - 28'sd8
                                : $signed({4'd0, acc_reg});
                            state_next = S_DCHK;
                        end
                    end
                    PH_DIST2:
                    begin
                        dist_next = $signed({4'd0, first_reg})
                            + $signed({2'b00, acc_reg, 2'b00}) - 28'sd7;
                        state_next = S_DCHK;
                    end
                    default:
                    begin
                        // length code
                        crem_next  = acc_reg;
                        phase_next = PH_FLAG;
                        state_next = (acc_reg != 24'd0) ? S_CPRD : S_STEP;
                    end
                endcase
            end

            S_PULL:
            begin
                if (phase_reg == PH_ERROR)
                begin
                    pend_next  = '{out_byte: 8'd0, status: ST_ERROR, error_code: err_reg,
                                   last: 1'b0};
                    state_next = S_EMIT;
                end
                else if (phase_reg < PH_FLAG)
                begin
                    pend_next  = more_rsp;
                    state_next = S_EMIT;
                end
                else if (produced_reg >= total_reg)
                begin
                    pend_next  = '{out_byte: 8'd0, status: ST_DONE, error_code: ERR_NONE,
                                   last: 1'b0};
                    state_next = S_EMIT;
                end
                else if (crem_reg != 24'd0)
                begin
                    state_next = S_CPRD;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end

            S_STEP:
            begin
                case (phase_reg)
                    PH_FLAG:
                    begin
                        if (held_reg == 6'd0)
                        begin
                            pend_next  = more_rsp;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            held_next = held_m1;
                            if (cur_bit)
                            begin
                                phase_next = PH_DIST1;
                                walk_next  = droot_reg;
                            end
                            else
                            begin
                                phase_next = PH_LIT;
                            end
                        end
                    end
                    PH_LIT:
                    begin
                        if (held_reg < 6'd8)
                        begin
                            pend_next  = more_rsp;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cnt_next   = 5'd8;
                            acc_next   = '0;
                            state_next = S_BITS;
                        end
                    end
                    default:
                    begin
                        // code walk, empty trees give zero at once
                        if ((phase_reg == PH_LEN) ? lempty_reg : dempty_reg)
                        begin
                            acc_next   = '0;
                            state_next = S_VALUE;
                        end
                        else
                        begin
                            tree_re    = 1'b1;
                            state_next = S_WALK;
                        end
                    end
                endcase
            end

            S_WALK:
            begin
                if (tree_rnode.is_leaf)
                begin
                    if (tree_rnode.bits > 8'(MAX_VALUE_BITS))
                    begin
                        err_next   = ERR_WIDE;
                        phase_next = PH_ERROR;
                        pend_next  = '{out_byte: 8'd0, status: ST_ERROR,
                                       error_code: ERR_WIDE, last: 1'b0};
                        state_next = S_EMIT;
                    end
                    else if ({2'b00, held_reg} < tree_rnode.bits)
                    begin
                        pend_next  = more_rsp;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cnt_next   = tree_rnode.bits[4:0];
                        acc_next   = '0;
                        state_next = S_BITS;
                    end
                end
                else if (held_reg == 6'd0)
                begin
                    pend_next  = more_rsp;
                    state_next = S_EMIT;
                end
                else
                begin
                    walk_next  = cur_bit ? tree_rnode.hi : tree_rnode.lo;
                    held_next  = held_m1;
                    state_next = S_STEP;
                end
            end

            S_DCHK:
            begin
                if (dist_bad)
                begin
                    err_next   = ERR_DISTANCE;
                    phase_next = PH_ERROR;
                    pend_next  = '{out_byte: 8'd0, status: ST_ERROR,
                                   error_code: ERR_DISTANCE, last: 1'b0};
                    state_next = S_EMIT;
                end
                else
                begin
                    cdist_next = dist_reg[12:0];
                    walk_next  = lroot_reg;
                    phase_next = PH_LEN;
                    state_next = S_STEP;
                end
            end

            S_CPRD:
            begin
                hist_re    = 1'b1;
                state_next = S_CPWR;
            end

            S_CPWR:
            begin
                // copy one byte out of the history ring
                hist_we       = 1'b1;
                hist_wdata    = hist_rdata;
                produced_next = produced_p1;
                crem_next     = crem_reg - 24'd1;
                pend_next     = '{out_byte: hist_rdata, status: ST_BYTE,
                                  error_code: ERR_NONE, last: (produced_p1 == total_reg)};
                state_next    = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (state_reg == S_EMIT && out_free)
        begin
            res_valid_next = 1'b1;
            res_next       = pend_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_HEADER;
            buf_reg       <= '0;
            held_reg      <= '0;
            total_reg     <= '0;
            method_reg    <= 1'b0;
            hdr_cnt_reg   <= '0;
            err_reg       <= ERR_NONE;
            depth_reg     <= '0;
            nc_reg        <= '0;
            top_reg       <= '0;
            walk_reg      <= '0;
            droot_reg     <= '0;
            lroot_reg     <= '0;
            dempty_reg    <= 1'b0;
            lempty_reg    <= 1'b0;
            produced_reg  <= '0;
            cdist_reg     <= '0;
            crem_reg      <= '0;
            first_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            buf_reg       <= buf_next;
            held_reg      <= held_next;
            total_reg     <= total_next;
            method_reg    <= method_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            err_reg       <= err_next;
            depth_reg     <= depth_next;
            nc_reg        <= nc_next;
            top_reg       <= top_next;
            walk_reg      <= walk_next;
            droot_reg     <= droot_next;
            lroot_reg     <= lroot_next;
            dempty_reg    <= dempty_next;
            lempty_reg    <= lempty_next;
            produced_reg  <= produced_next;
            cdist_reg     <= cdist_next;
            crem_reg      <= crem_next;
            first_reg     <= first_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        cnt_reg  <= cnt_next;
        dist_reg <= dist_next;
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

endmodule
